// ===== rtl/sgms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgms_pkg
// Shared widths, fixed-point constants and stage payload types for the
// stereo geometric-mean shaper.
// ----------------------------------------------------------------------------
package sgms_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int INT_FRAC        = 30;

    localparam int AMOUNT_BITS = 16;
    localparam logic [AMOUNT_BITS:0] AMOUNT_ONE = {1'b1, {AMOUNT_BITS{1'b0}}};

    // 0.3 in Q46, split so each partial product stays narrow
    localparam int SOAR_Q46_BITS = 45;
    localparam logic [SOAR_Q46_BITS-1:0] SOAR_Q46 = 45'd21110623253299;
    localparam int SOAR_SPLIT = 23;
    localparam int SOAR_HI_BITS = SOAR_Q46_BITS - SOAR_SPLIT;
    localparam logic [SOAR_HI_BITS-1:0] SOAR_HI = SOAR_Q46[SOAR_Q46_BITS-1:SOAR_SPLIT];
    localparam logic [SOAR_SPLIT-1:0] SOAR_LO = SOAR_Q46[SOAR_SPLIT-1:0];

    localparam int PHI_BITS  = SOAR_HI_BITS + AMOUNT_BITS + 1;
    localparam int PLO_BITS  = SOAR_SPLIT + AMOUNT_BITS + 1;
    localparam int SUM_BITS  = 63;
    localparam int SOAR_BITS = 29;
    localparam int SQP_BITS  = 2 * SOAR_BITS;
    localparam int SQ_BITS   = 27;

    localparam int Q30_BITS  = INT_FRAC + 1;
    localparam int WORK_BITS = 33;
    localparam int PROD_BITS = 2 * Q30_BITS;
    localparam int ROOT_BITS = Q30_BITS;
    localparam int REM_BITS  = ROOT_BITS + 2;
    localparam int G_BITS    = ROOT_BITS + 1;

    localparam int SETTLE_CYCLES = 4;
    localparam int SETTLE_BITS   = 3;

    typedef struct packed {
        logic [SOAR_BITS-1:0] soar;
        logic [SQ_BITS-1:0]   sq;
    } offset_t;

    typedef struct packed {
        logic [PROD_BITS-1:0] prod;
        logic                 neg;
    } prod_t;

    typedef struct packed {
        logic [ROOT_BITS-1:0] root;
        logic [REM_BITS-1:0]  rem;
        logic                 neg;
    } root_t;

endpackage

// ===== rtl/sgms_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgms channel interfaces
// Valid/ready channels for the stereo input, the mono result and the
// amount register write port.
// ----------------------------------------------------------------------------
interface sgms_pair_if import sgms_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;

    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface sgms_sample_if import sgms_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_sample;

    modport source (output valid, output out_sample, input ready);
    modport sink   (input valid, input out_sample, output ready);
endinterface

interface sgms_cfg_if import sgms_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [AMOUNT_BITS-1:0] amount;

    modport source (output valid, output amount, input ready);
    modport sink   (input valid, input amount, output ready);
endinterface

// ===== rtl/sgms_offset.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgms_offset
// Amount register and the derived offset soar and soar squared, both Q30,
// recomputed through a short register chain after every write.
// ----------------------------------------------------------------------------
module sgms_offset import sgms_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    sgms_cfg_if.sink     cfg,
    output offset_t      offset,
    output logic         settled
);

    logic [AMOUNT_BITS-1:0] amount_reg;
    logic [SETTLE_BITS-1:0] settle_cnt_reg;
    logic [AMOUNT_BITS:0]   span;
    logic [PHI_BITS-1:0]    phi_reg;
    logic [PLO_BITS-1:0]    plo_reg;
    logic [SUM_BITS-1:0]    soar_sum;
    logic [SOAR_BITS-1:0]   soar_reg;
    logic [SQP_BITS-1:0]    sqp_reg;
    logic [SQP_BITS:0]      sq_sum;
    logic [SQ_BITS-1:0]     sq_reg;
    logic                   wr;

    assign cfg.ready = 1'b1;
    assign wr        = cfg.valid && cfg.ready;
    assign span      = AMOUNT_ONE - {1'b0, amount_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amount_reg     <= '0;
            settle_cnt_reg <= SETTLE_BITS'(SETTLE_CYCLES);
        end
        else if (wr)
        begin
            amount_reg     <= cfg.amount;
            settle_cnt_reg <= SETTLE_BITS'(SETTLE_CYCLES);
        end
        else if (settle_cnt_reg != '0)
        begin
            settle_cnt_reg <= settle_cnt_reg - 1'b1;
        end
    end

    // soar = (0.3 * 2^46 * (65536 - amount) + 2^31) >> 32
    assign soar_sum = (SUM_BITS'(phi_reg) << SOAR_SPLIT) + SUM_BITS'(plo_reg)
                      + (SUM_BITS'(1) << 31);
    assign sq_sum   = (SQP_BITS + 1)'(sqp_reg) + ((SQP_BITS + 1)'(1) << (INT_FRAC - 1));

    always_ff @(posedge clk)
    begin
        phi_reg  <= PHI_BITS'(SOAR_HI) * PHI_BITS'(span);
        plo_reg  <= PLO_BITS'(SOAR_LO) * PLO_BITS'(span);
        soar_reg <= soar_sum[32 +: SOAR_BITS];
        sqp_reg  <= SQP_BITS'(soar_reg) * SQP_BITS'(soar_reg);
        sq_reg   <= sq_sum[INT_FRAC +: SQ_BITS];
    end

    assign offset.soar = soar_reg;
    assign offset.sq   = sq_reg;
    assign settled     = (settle_cnt_reg == '0);

endmodule

// ===== rtl/sgms_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgms_front
// Three-stage front end: sample magnitudes in Q30, add soar squared, then
// multiply the two biased magnitudes.
// ----------------------------------------------------------------------------
module sgms_front import sgms_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] left_sample,
    input  logic signed [SAMPLE_BITS-1:0] right_sample,
    input  offset_t                       offset,
    output logic                          out_valid,
    input  logic                          out_ready,
    output prod_t                         out_data
);

    localparam int STAGES = 3;
    localparam int FRAC   = SAMPLE_BITS - 1;
    localparam int MAG_DN = (FRAC > INT_FRAC) ? FRAC - INT_FRAC : 0;
    localparam int MAG_UP = (FRAC > INT_FRAC) ? 0 : INT_FRAC - FRAC;
    localparam logic [WORK_BITS-1:0] MAG_RND = WORK_BITS'((1 << MAG_DN) >> 1);

    function automatic logic [Q30_BITS-1:0] to_q30(input logic [SAMPLE_BITS-1:0] x);
        logic [SAMPLE_BITS-1:0] mag;
        logic [WORK_BITS-1:0]   ext;
        mag = x[SAMPLE_BITS-1] ? (~x + 1'b1) : x;
        ext = ((WORK_BITS'(mag) + MAG_RND) >> MAG_DN) << MAG_UP;
        return ext[Q30_BITS-1:0];
    endfunction

    logic [STAGES-1:0]    vld_reg;
    logic [STAGES-1:0]    vld_src;
    logic [STAGES-1:0]    en;
    logic [STAGES-1:0]    neg_reg;
    logic [Q30_BITS-1:0]  magl_reg;
    logic [Q30_BITS-1:0]  magr_reg;
    logic [Q30_BITS-1:0]  a_reg;
    logic [Q30_BITS-1:0]  b_reg;
    logic [PROD_BITS-1:0] prod_reg;

    // a stage advances when it is empty or the one after it advances
    always_comb
    begin
        en[STAGES-1] = !vld_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign vld_src  = {vld_reg[STAGES-2:0], in_valid};
    assign in_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_src[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            magl_reg   <= to_q30($unsigned(left_sample));
            magr_reg   <= to_q30($unsigned(right_sample));
            neg_reg[0] <= left_sample[SAMPLE_BITS-1] ^ right_sample[SAMPLE_BITS-1];
        end
        if (en[1])
        begin
            a_reg      <= magl_reg + Q30_BITS'(offset.sq);
            b_reg      <= magr_reg + Q30_BITS'(offset.sq);
            neg_reg[1] <= neg_reg[0];
        end
        if (en[2])
        begin
            prod_reg   <= PROD_BITS'(a_reg) * PROD_BITS'(b_reg);
            neg_reg[2] <= neg_reg[1];
        end
    end

    assign out_valid     = vld_reg[STAGES-1];
    assign out_data.prod = prod_reg;
    assign out_data.neg  = neg_reg[STAGES-1];

endmodule

// ===== rtl/sgms_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgms_isqrt
// Pipelined restoring square root: one root bit per stage, with the final
// remainder passed on for round-to-nearest.
// ----------------------------------------------------------------------------
module sgms_isqrt import sgms_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  prod_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output root_t out_data
);

    localparam int STAGES = ROOT_BITS;

    logic [STAGES-1:0]    vld_reg;
    logic [STAGES-1:0]    vld_src;
    logic [STAGES-1:0]    en;
    logic [ROOT_BITS-1:0] q_reg   [STAGES];
    logic [ROOT_BITS-1:0] q_next  [STAGES];
    logic [REM_BITS-1:0]  r_reg   [STAGES];
    logic [REM_BITS-1:0]  r_next  [STAGES];
    logic [PROD_BITS-1:0] v_reg   [STAGES];
    logic [PROD_BITS-1:0] v_next  [STAGES];
    logic [STAGES-1:0]    n_reg;
    logic [STAGES-1:0]    n_next;

    for (genvar k = 0; k < STAGES; k++)
    begin : g_step
        logic [ROOT_BITS-1:0] q_p;
        logic [REM_BITS-1:0]  r_p;
        logic [PROD_BITS-1:0] v_p;
        logic                 n_p;
        logic [REM_BITS+1:0]  rs;
        logic [REM_BITS+1:0]  trial;
        logic                 take;

        if (k == 0)
        begin : g_first
            assign q_p = '0;
            assign r_p = '0;
            assign v_p = in_data.prod;
            assign n_p = in_data.neg;
        end
        else
        begin : g_rest
            assign q_p = q_reg[k-1];
            assign r_p = r_reg[k-1];
            assign v_p = v_reg[k-1];
            assign n_p = n_reg[k-1];
        end

        // bring down the next two radicand bits and try root bit one
        assign rs        = {r_p, v_p[PROD_BITS-1 -: 2]};
        assign trial     = {2'b00, q_p, 2'b01};
        assign take      = (rs >= trial);
        assign q_next[k] = {q_p[ROOT_BITS-2:0], take};
        assign r_next[k] = take ? REM_BITS'(rs - trial) : rs[REM_BITS-1:0];
        assign v_next[k] = v_p << 2;
        assign n_next[k] = n_p;
    end

    always_comb
    begin
        en[STAGES-1] = !vld_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign vld_src  = {vld_reg[STAGES-2:0], in_valid};
    assign in_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_src[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < STAGES; k++)
        begin
            if (en[k])
            begin
                q_reg[k] <= q_next[k];
                r_reg[k] <= r_next[k];
                v_reg[k] <= v_next[k];
                n_reg[k] <= n_next[k];
            end
        end
    end

    assign out_valid     = vld_reg[STAGES-1];
    assign out_data.root = q_reg[STAGES-1];
    assign out_data.rem  = r_reg[STAGES-1];
    assign out_data.neg  = n_reg[STAGES-1];

endmodule

// ===== rtl/sgms_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgms_back
// Back end: round the root, take off soar, move to the sample format,
// saturate and apply the sign. The last stage is the output register.
// ----------------------------------------------------------------------------
module sgms_back import sgms_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  root_t                         in_data,
    input  offset_t                       offset,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] out_sample
);

    localparam int STAGES = 4;
    localparam int FRAC   = SAMPLE_BITS - 1;
    localparam int OUT_DN = (FRAC >= INT_FRAC) ? 0 : INT_FRAC - FRAC;
    localparam int OUT_UP = (FRAC >= INT_FRAC) ? FRAC - INT_FRAC : 0;
    localparam logic [WORK_BITS-1:0] OUT_RND = WORK_BITS'((1 << OUT_DN) >> 1);
    localparam logic [WORK_BITS-1:0] CAP_NEG = WORK_BITS'(1) << FRAC;
    localparam logic [WORK_BITS-1:0] CAP_POS = CAP_NEG - 1'b1;

    logic [STAGES-1:0]      vld_reg;
    logic [STAGES-1:0]      vld_src;
    logic [STAGES-1:0]      en;
    logic [STAGES-2:0]      neg_reg;
    logic [G_BITS-1:0]      g_reg;
    logic [G_BITS-1:0]      m_reg;
    logic [WORK_BITS-1:0]   scaled_reg;
    logic [SAMPLE_BITS-1:0] out_reg;
    logic [G_BITS-1:0]      soar_ext;
    logic [WORK_BITS-1:0]   cap;
    logic [WORK_BITS-1:0]   capped;
    logic [SAMPLE_BITS-1:0] out_next;

    always_comb
    begin
        en[STAGES-1] = !vld_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign vld_src  = {vld_reg[STAGES-2:0], in_valid};
    assign in_ready = en[0];
    assign soar_ext = G_BITS'(offset.soar);

    // saturate on the magnitude, then negate when the input signs differ
    always_comb
    begin
        cap      = neg_reg[2] ? CAP_NEG : CAP_POS;
        capped   = (scaled_reg > cap) ? cap : scaled_reg;
        out_next = neg_reg[2] ? (~capped[SAMPLE_BITS-1:0] + 1'b1) : capped[SAMPLE_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_src[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            // round up when the remainder exceeds the floor root
            g_reg      <= G_BITS'(in_data.root)
                          + G_BITS'(in_data.rem > REM_BITS'(in_data.root));
            neg_reg[0] <= in_data.neg;
        end
        if (en[1])
        begin
            m_reg      <= (g_reg > soar_ext) ? (g_reg - soar_ext) : '0;
            neg_reg[1] <= neg_reg[0];
        end
        if (en[2])
        begin
            scaled_reg <= ((WORK_BITS'(m_reg) + OUT_RND) >> OUT_DN) << OUT_UP;
            neg_reg[2] <= neg_reg[1];
        end
        if (en[3])
        begin
            out_reg    <= out_next;
        end
    end

    assign out_valid  = vld_reg[STAGES-1];
    assign out_sample = $signed(out_reg);

endmodule

// ===== rtl/stereo_geometric_mean_shaper_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipeline: 3 front, 31 square-root and 4 back-end stages; one pair per cycle
//   sustained while the result side is ready and the offset has settled.
// The square root produces one root bit per stage; any stage that holds an
//   empty slot takes new data while later stages are stalled.
// Reset clears all valid bits and sets amount to 0 (soar 0.3). Input is held
//   off after reset and after each amount write while soar settles.
// ----------------------------------------------------------------------------
// stereo_geometric_mean_shaper_unit
// Top level: mono geometric-mean shaping of a stereo pair, amount register.
// ----------------------------------------------------------------------------
module stereo_geometric_mean_shaper_unit import sgms_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    sgms_pair_if.sink     pair,
    sgms_sample_if.source result,
    sgms_cfg_if.sink      cfg
);

    offset_t offset;
    logic    settled;
    logic    front_valid;
    logic    front_ready;
    prod_t   prod_data;
    logic    prod_valid;
    logic    prod_ready;
    root_t   root_data;
    logic    root_valid;
    logic    root_ready;

    sgms_offset u_offset (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .offset  (offset),
        .settled (settled)
    );

    // hold the input while the offset chain settles
    assign front_valid = pair.valid && settled;
    assign pair.ready  = front_ready && settled;

    sgms_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (front_valid),
        .in_ready     (front_ready),
        .left_sample  (pair.left_sample),
        .right_sample (pair.right_sample),
        .offset       (offset),
        .out_valid    (prod_valid),
        .out_ready    (prod_ready),
        .out_data     (prod_data)
    );

    sgms_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_data   (prod_data),
        .out_valid (root_valid),
        .out_ready (root_ready),
        .out_data  (root_data)
    );

    sgms_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (root_valid),
        .in_ready   (root_ready),
        .in_data    (root_data),
        .offset     (offset),
        .out_valid  (result.valid),
        .out_ready  (result.ready),
        .out_sample (result.out_sample)
    );

    a_settle_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg.valid && cfg.ready) |=> !pair.ready)
        else $error("input accepted while the offset was settling");

    a_root_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        root_valid |-> (root_data.rem <= {1'b0, root_data.root, 1'b0}))
        else $error("square root remainder exceeds twice the root");

    a_no_input_unsettled: assert property (@(posedge clk) disable iff (!rst_n)
        !settled |-> !(pair.valid && pair.ready))
        else $error("input transfer before offset settled");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the stereo geometric-mean shaper. A fixed table of
// pairs and then random pairs go through the block under several amount
// settings. Each result is compared with a bit-exact fixed-point prediction.
// Both sides of the block idle in random bursts, with one long output stall.
// ----------------------------------------------------------------------------
module testbench;
    import sgms_pkg::*;

    localparam int SB               = SAMPLE_BITS_DEF;
    localparam int Q_SHIFT          = 30 - (SB - 1);
    localparam logic [63:0] OFFSET_Q46 = 64'd21110623253299;  // 0.3 * 2^46
    localparam logic [SB-1:0] S_MAX  = {1'b0, {(SB-1){1'b1}}};
    localparam logic [SB-1:0] S_MIN  = {1'b1, {(SB-1){1'b0}}};
    localparam logic [SB-1:0] S_NEG1 = '1;
    localparam logic [SB-1:0] S_ONE  = SB'(1);
    localparam logic [SB-1:0] S_ZERO = '0;
    // magnitude at which the mean just crosses the offset when amount is 0
    localparam logic [SB-1:0] KNEE   = SB'(1761607);
    localparam int N_ROWS           = 21;
    localparam int N_PHASES         = 8;
    localparam int RANDOM_PER_PHASE = 136;
    localparam int HOLD_CYCLES      = 200;
    localparam int TAIL_CYCLES      = 48;
    localparam int CYCLE_LIMIT      = 200000;

    typedef struct packed {
        logic [SB-1:0] left;
        logic [SB-1:0] right;
        logic          typed;
        logic [SB-1:0] want;
    } pair_row_t;

    logic clk;
    logic rst_n;

    sgms_pair_if   #(.SAMPLE_BITS(SB)) pair_ch ();
    sgms_sample_if #(.SAMPLE_BITS(SB)) result_ch ();
    sgms_cfg_if                        cfg_ch ();

    logic [AMOUNT_BITS-1:0] amount_now = '0;
    logic [SB-1:0]          shaped_q [$];
    logic                   row_typed;
    logic [SB-1:0]          row_want;
    int                     mismatches = 0;
    int                     cycles = 0;
    bit                     idle_on = 1'b1;
    bit                     hold_request = 1'b0;

    pair_row_t shaper_rows [N_ROWS] = '{
        '{S_ZERO, S_ZERO, 1'b1, S_ZERO},
        '{S_ZERO, S_NEG1, 1'b1, S_ZERO},
        '{S_NEG1, S_ZERO, 1'b1, S_ZERO},
        '{S_NEG1, S_NEG1, 1'b1, S_ZERO},
        '{S_ONE,  S_NEG1, 1'b1, S_ZERO},
        '{S_MAX,  S_MAX,  1'b0, S_ZERO},
        '{S_MIN,  S_MIN,  1'b0, S_ZERO},
        '{S_MAX,  S_MIN,  1'b0, S_ZERO},
        '{S_MIN,  S_MAX,  1'b0, S_ZERO},
        '{S_ZERO, S_MAX,  1'b0, S_ZERO},
        '{S_MIN,  S_ZERO, 1'b0, S_ZERO},
        '{S_ZERO, S_MIN,  1'b0, S_ZERO},
        '{S_MAX,  S_ZERO, 1'b0, S_ZERO},
        '{KNEE,   KNEE,   1'b0, S_ZERO},
        '{KNEE + S_ONE, KNEE + S_ONE, 1'b0, S_ZERO},
        '{-KNEE,  KNEE,   1'b0, S_ZERO},
        '{-(KNEE + S_ONE), KNEE + S_ONE, 1'b0, S_ZERO},
        '{-(KNEE + S_ONE), -(KNEE + S_ONE), 1'b0, S_ZERO},
        '{24'h555555, 24'hAAAAAA, 1'b0, S_ZERO},
        '{24'hAAAAAA, 24'h555555, 1'b0, S_ZERO},
        '{S_MIN,  S_NEG1, 1'b0, S_ZERO}
    };

    stereo_geometric_mean_shaper_unit #(.SAMPLE_BITS(SB)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pair   (pair_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // square root rounded to the nearest integer
    function automatic logic [63:0] root_nearest(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] t;
        r = 64'd0;
        for (int k = 31; k >= 0; k--)
        begin
            t = r | (64'd1 << k);
            if (t * t <= v)
                r = t;
        end
        if (v - r * r > r)
            r = r + 64'd1;
        return r;
    endfunction

    function automatic logic [SB-1:0] shape_pair(input logic [SB-1:0] l,
                                                 input logic [SB-1:0] r,
                                                 input logic [AMOUNT_BITS-1:0] amt);
        logic [63:0] mag_l;
        logic [63:0] mag_r;
        logic [63:0] soar;
        logic [63:0] sq;
        logic [63:0] g;
        logic [63:0] m;
        logic [63:0] cap;
        bit          neg;
        mag_l = l[SB-1] ? (64'd1 << SB) - 64'(l) : 64'(l);
        mag_r = r[SB-1] ? (64'd1 << SB) - 64'(r) : 64'(r);
        mag_l = mag_l << Q_SHIFT;
        mag_r = mag_r << Q_SHIFT;
        soar  = (OFFSET_Q46 * (64'd65536 - 64'(amt)) + (64'd1 << 31)) >> 32;
        sq    = (soar * soar + (64'd1 << 29)) >> 30;
        g     = root_nearest((mag_l + sq) * (mag_r + sq));
        m     = (g > soar) ? g - soar : 64'd0;
        // round half up on the magnitude, sign applied afterwards
        m     = (m + (64'd1 << (Q_SHIFT - 1))) >> Q_SHIFT;
        neg   = l[SB-1] ^ r[SB-1];
        cap   = neg ? (64'd1 << (SB - 1)) : (64'd1 << (SB - 1)) - 64'd1;
        if (m > cap)
            m = cap;
        if (neg)
            m = -m;
        return m[SB-1:0];
    endfunction

    function automatic logic [SB-1:0] rand_sample();
        logic signed [SB-1:0] v;
        v = SB'($urandom);
        case ($urandom_range(0, 9))
            0: v = S_MAX;
            1: v = S_MIN;
            2: v = S_ZERO;
            3, 4, 5: v = v >>> $urandom_range(1, SB - 1);
            default: ;
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string what, input logic [SB-1:0] got,
                                   input logic [SB-1:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // offer one pair and hold it until the transfer; valid stays high after
    task automatic send_pair(input logic [SB-1:0] l, input logic [SB-1:0] r,
                             input bit typed, input logic [SB-1:0] want);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            pair_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        pair_ch.valid        <= 1'b1;
        pair_ch.left_sample  <= l;
        pair_ch.right_sample <= r;
        row_typed            <= typed;
        row_want             <= want;
        @(posedge clk);
        while (!pair_ch.ready)
            @(posedge clk);
    endtask

    task automatic wait_for_drain();
        pair_ch.valid <= 1'b0;
        @(posedge clk);
        while (shaped_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_amount(input logic [AMOUNT_BITS-1:0] v);
        wait_for_drain();
        cfg_ch.valid  <= 1'b1;
        cfg_ch.amount <= v;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic walk_rows(input bit use_typed);
        for (int i = 0; i < N_ROWS; i++)
            send_pair(shaper_rows[i].left, shaper_rows[i].right,
                      use_typed && shaper_rows[i].typed, shaper_rows[i].want);
    endtask

    // output side: random stalls, and one long hold-off on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                stall_left   = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            else if (stall_left > 0)
                stall_left--;
            else if (idle_on && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 11);
            result_ch.ready <= (stall_left == 0);
        end
    end

    always @(posedge clk)
    begin : check_flow
        logic [SB-1:0] want;
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                amount_now <= cfg_ch.amount;
            if (pair_ch.valid && pair_ch.ready)
                shaped_q.push_back(row_typed ? row_want :
                                   shape_pair(pair_ch.left_sample, pair_ch.right_sample,
                                              amount_now));
            if (result_ch.valid && result_ch.ready)
            begin
                if (shaped_q.size() == 0)
                    report_mismatch("result with nothing pending", result_ch.out_sample, 'x);
                else
                begin
                    want = shaped_q.pop_front();
                    if (result_ch.out_sample !== want)
                        report_mismatch("out_sample", result_ch.out_sample, want);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [AMOUNT_BITS-1:0] amt;
        pair_ch.valid        <= 1'b0;
        pair_ch.left_sample  <= '0;
        pair_ch.right_sample <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.amount        <= '0;
        row_typed            <= 1'b0;
        row_want             <= '0;
        rst_n                <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        walk_rows(1'b1);

        for (int p = 0; p < N_PHASES; p++)
        begin
            case (p)
                0:       amt = 16'hFFFF;
                1:       amt = 16'h0001;
                2:       amt = 16'h8000;
                3:       amt = 16'h0000;
                default: amt = AMOUNT_BITS'($urandom);
            endcase
            idle_on = (p != N_PHASES - 1);
            write_amount(amt);
            if (p < 2)
                walk_rows(1'b0);
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
            begin
                // stall the output long enough to fill the pipeline and back up the input
                if (p == 2 && i == 20)
                    hold_request = 1'b1;
                if (p == 3 && i == RANDOM_PER_PHASE / 2)
                    wait_for_drain();
                send_pair(rand_sample(), rand_sample(), 1'b0, S_ZERO);
            end
        end

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/sgms_pkg.sv
rtl/sgms_if.sv
rtl/sgms_offset.sv
rtl/sgms_front.sv
rtl/sgms_isqrt.sv
rtl/sgms_back.sv
rtl/stereo_geometric_mean_shaper_unit.sv
sim/testbench.sv
